// ===== hdl/assert_macros.svh =====
// Assertion helpers, clocked and reset-gated.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AST_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/i2cm_pkg.sv =====
package i2cm_pkg;

    typedef enum logic [2:0] {
        KIND_NONE  = 3'd0,
        KIND_START = 3'd1,
        KIND_STOP  = 3'd2,
        KIND_SEND  = 3'd3,
        KIND_WACK  = 3'd4,
        KIND_READ  = 3'd5
    } kind_t;

    typedef enum logic [15:0] {
        PH_IDLE    = 16'h0001,
        PH_ST_A    = 16'h0002,
        PH_ST_B    = 16'h0004,
        PH_SP_PREP = 16'h0008,
        PH_SP_A    = 16'h0010,
        PH_SP_B    = 16'h0020,
        PH_TX_SET  = 16'h0040,
        PH_TX_HI   = 16'h0080,
        PH_TX_LO   = 16'h0100,
        PH_WA_A    = 16'h0200,
        PH_WA_B    = 16'h0400,
        PH_WA_POLL = 16'h0800,
        PH_RX_LO   = 16'h1000,
        PH_RX_HI   = 16'h2000,
        PH_AK_LO   = 16'h4000,
        PH_AK_HI   = 16'h8000
    } phase_t;

    typedef enum logic {
        CFG_TICKS_PER_US = 1'b0,
        CFG_ACK_TIMEOUT  = 1'b1
    } cfg_idx_t;

    localparam logic [7:0] TPU_RESET     = 8'd8;
    localparam logic [7:0] TIMEOUT_RESET = 8'd250;
    localparam logic [2:0] START_HOLD    = 3'd5;
    localparam logic [2:0] STOP_HOLD     = 3'd6;
    localparam logic [2:0] BIT_UNITS     = 3'd2;
    localparam logic [2:0] ACK_HIGH      = 3'd5;
    localparam logic [2:0] ONE_UNIT      = 3'd1;
    localparam logic [2:0] LAST_BIT      = 3'd7;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] write_byte;
        logic       ack_after_read;
        logic       sda_sample;
    } req_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_failed;
    } res_t;

endpackage

// ===== hdl/i2c_master_bit_sequencer.sv =====
// A request's result is registered on acceptance and is valid in the next cycle.
// Throughput: one request per cycle; the result register frees as it is taken,
// so s_ready only drops while a result waits with m_ready low.
// Reset: synchronous, active-low aresetn; idle phase, SCL/SDA driven high,
// ticks_per_us = 8, ack_timeout = 250, read byte and failure flag cleared.
module i2c_master_bit_sequencer
    import i2cm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  req_t       s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output res_t       m_data
);

`include "assert_macros.svh"

    logic [7:0] tpu_reg;
    logic [7:0] timeout_reg;

    phase_t     phase_reg, phase_next;
    logic [2:0] dc_reg, dc_next;
    logic [7:0] pc_reg, pc_next;
    logic [2:0] bit_reg, bit_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] tc_reg, tc_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       drv_reg, drv_next;
    logic       fail_reg, fail_next;
    logic       ackc_reg, ackc_next;
    logic [7:0] rx_reg, rx_next;

    logic       m_valid_reg;
    res_t       m_data_reg;
    res_t       res;
    logic       s_fire;
    logic       done;

    logic [7:0] tpu_lim;
    logic [7:0] to_lim;
    logic [8:0] pc_inc;
    logic       tick;
    logic [2:0] dc_dec;
    logic [7:0] tc_inc;
    logic [7:0] rx_shift;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpu_reg     <= TPU_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TICKS_PER_US: tpu_reg     <= cfg_data;
                CFG_ACK_TIMEOUT:  timeout_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // zero settings act as one
    assign tpu_lim  = (tpu_reg == 8'd0) ? 8'd1 : tpu_reg;
    assign to_lim   = (timeout_reg == 8'd0) ? 8'd1 : timeout_reg;
    assign pc_inc   = {1'b0, pc_reg} + 9'd1;
    assign tick     = pc_inc >= {1'b0, tpu_lim};
    assign dc_dec   = (dc_reg != 3'd0) ? dc_reg - 3'd1 : 3'd0;
    assign tc_inc   = tc_reg + 8'd1;
    assign rx_shift = {shift_reg[6:0], s_data.sda_sample};

    always_comb begin
        phase_next = phase_reg;
        dc_next    = dc_reg;
        pc_next    = pc_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        tc_next    = tc_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        drv_next   = drv_reg;
        fail_next  = fail_reg;
        ackc_next  = ackc_reg;
        rx_next    = rx_reg;
        done       = 1'b0;
        unique case (phase_reg)
            PH_IDLE: begin
                case (s_data.kind)
                    KIND_START: begin
                        drv_next = 1'b1; sda_next = 1'b1; scl_next = 1'b1;
                        phase_next = PH_ST_A; dc_next = START_HOLD; pc_next = 8'd0;
                    end
                    KIND_STOP: begin
                        scl_next = 1'b0; sda_next = 1'b0; drv_next = 1'b1;
                        phase_next = PH_SP_PREP; dc_next = 3'd0; pc_next = 8'd0;
                    end
                    KIND_SEND: begin
                        shift_next = s_data.write_byte; bit_next = 3'd0;
                        drv_next = 1'b1; scl_next = 1'b0;
                        sda_next = s_data.write_byte[7];
                        phase_next = PH_TX_SET; dc_next = BIT_UNITS; pc_next = 8'd0;
                    end
                    KIND_WACK: begin
                        drv_next = 1'b0; sda_next = 1'b1; fail_next = 1'b0;
                        tc_next = 8'd0;
                        phase_next = PH_WA_A; dc_next = ONE_UNIT; pc_next = 8'd0;
                    end
                    KIND_READ: begin
                        drv_next = 1'b0; sda_next = 1'b1;
                        ackc_next = s_data.ack_after_read;
                        bit_next = 3'd0; shift_next = 8'd0; scl_next = 1'b0;
                        phase_next = PH_RX_LO; dc_next = BIT_UNITS; pc_next = 8'd0;
                    end
                    default: ;
                endcase
            end
            PH_SP_PREP: begin
                scl_next = 1'b1;
                phase_next = PH_SP_A; dc_next = STOP_HOLD; pc_next = 8'd0;
            end
            PH_WA_POLL: begin
                if (!s_data.sda_sample) begin
                    scl_next = 1'b0; phase_next = PH_IDLE; done = 1'b1;
                end else begin
                    pc_next = tick ? 8'd0 : pc_inc[7:0];
                    if (tick) begin
                        tc_next = tc_inc;
                        if (tc_inc >= to_lim) begin
                            fail_next = 1'b1;
                            scl_next = 1'b0; sda_next = 1'b0; drv_next = 1'b1;
                            phase_next = PH_SP_PREP; dc_next = 3'd0;
                        end
                    end
                end
            end
            default: begin
                pc_next = tick ? 8'd0 : pc_inc[7:0];
                if (tick) begin
                    dc_next = dc_dec;
                    if (dc_dec == 3'd0) begin
                        unique case (phase_reg)
                            PH_ST_A: begin
                                sda_next = 1'b0;
                                phase_next = PH_ST_B; dc_next = STOP_HOLD;
                            end
                            PH_ST_B: begin
                                scl_next = 1'b0; phase_next = PH_IDLE; done = 1'b1;
                            end
                            PH_SP_A: begin
                                sda_next = 1'b1;
                                phase_next = PH_SP_B; dc_next = STOP_HOLD;
                            end
                            PH_SP_B: begin
                                phase_next = PH_IDLE; done = 1'b1;
                            end
                            PH_TX_SET: begin
                                scl_next = 1'b1;
                                phase_next = PH_TX_HI; dc_next = BIT_UNITS;
                            end
                            PH_TX_HI: begin
                                scl_next = 1'b0;
                                phase_next = PH_TX_LO; dc_next = BIT_UNITS;
                            end
                            PH_TX_LO: begin
                                if (bit_reg == LAST_BIT) begin
                                    phase_next = PH_IDLE; done = 1'b1;
                                end else begin
                                    bit_next = bit_reg + 3'd1;
                                    shift_next = {shift_reg[6:0], 1'b0};
                                    sda_next = shift_reg[6];
                                    phase_next = PH_TX_SET; dc_next = BIT_UNITS;
                                end
                            end
                            PH_WA_A: begin
                                scl_next = 1'b1;
                                phase_next = PH_WA_B; dc_next = ONE_UNIT;
                            end
                            PH_WA_B: begin
                                phase_next = PH_WA_POLL; dc_next = 3'd0;
                            end
                            PH_RX_LO: begin
                                scl_next = 1'b1;
                                phase_next = PH_RX_HI; dc_next = ONE_UNIT;
                            end
                            PH_RX_HI: begin
                                shift_next = rx_shift;
                                scl_next = 1'b0;
                                if (bit_reg == LAST_BIT) begin
                                    rx_next = rx_shift;
                                    drv_next = 1'b1;
                                    sda_next = !ackc_reg;
                                    phase_next = PH_AK_LO; dc_next = BIT_UNITS;
                                end else begin
                                    bit_next = bit_reg + 3'd1;
                                    phase_next = PH_RX_LO; dc_next = BIT_UNITS;
                                end
                            end
                            PH_AK_LO: begin
                                scl_next = 1'b1;
                                phase_next = PH_AK_HI; dc_next = ACK_HIGH;
                            end
                            PH_AK_HI: begin
                                scl_next = 1'b0; phase_next = PH_IDLE; done = 1'b1;
                            end
                            default: phase_next = PH_IDLE;
                        endcase
                    end
                end
            end
        endcase
    end

    always_comb begin
        res.scl_level  = scl_next;
        res.sda_level  = drv_next ? sda_next : 1'b1;
        res.sda_drive  = drv_next;
        res.busy_res   = phase_next != PH_IDLE;
        res.done_res   = done;
        res.read_byte  = rx_next;
        res.ack_failed = fail_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            dc_reg    <= 3'd0;
            pc_reg    <= 8'd0;
            bit_reg   <= 3'd0;
            shift_reg <= 8'd0;
            tc_reg    <= 8'd0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            drv_reg   <= 1'b1;
            fail_reg  <= 1'b0;
            ackc_reg  <= 1'b0;
            rx_reg    <= 8'd0;
        end else if (s_fire) begin
            phase_reg <= phase_next;
            dc_reg    <= dc_next;
            pc_reg    <= pc_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            tc_reg    <= tc_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            drv_reg   <= drv_next;
            fail_reg  <= fail_next;
            ackc_reg  <= ackc_next;
            rx_reg    <= rx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= s_fire || (m_valid_reg && !m_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= res;
        end
    end

    `AST_IMPL(a_ready_when_empty, aclk, aresetn, !m_valid_reg, s_ready, "stalled while empty")
    `AST_IMPL(a_done_not_busy, aclk, aresetn, m_valid_reg && m_data_reg.done_res, !m_data_reg.busy_res, "done while busy")
    `AST_IMPL(a_stop_prep_lines, aclk, aresetn, phase_reg == PH_SP_PREP, !scl_reg && !sda_reg && drv_reg, "stop prep lines")
    `AST_NEXT(a_fire_loads_result, aclk, aresetn, s_fire, m_valid_reg, "result lost")

endmodule
